// ===== design/vmma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmma_pkg
// Shared constants, operation codes and types for the valid-masked
// moving average block.
// ----------------------------------------------------------------------------
package vmma_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 16;
   localparam int OP_W          = 2;

   localparam logic [OP_W-1:0] OP_GOOD  = 2'd0;
   localparam logic [OP_W-1:0] OP_FAIL  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== design/vmma_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmma_req_if / vmma_rsp_if
// Valid/ready channels for the moving average request and response beats.
// ----------------------------------------------------------------------------
interface vmma_req_if import vmma_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic signed [DATA_W-1:0] sample_value;

   modport source (output valid, output operation, output sample_value, input ready);
   modport sink   (input valid, input operation, input sample_value, output ready);
endinterface

interface vmma_rsp_if import vmma_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     last_ok;
   logic signed [DATA_W-1:0] last_value;
   logic                     average_ok;
   logic signed [DATA_W-1:0] average_value;

   modport source (output valid, output last_ok, output last_value,
                   output average_ok, output average_value, input ready);
   modport sink   (input valid, input last_ok, input last_value,
                   input average_ok, input average_value, output ready);
endinterface

// ===== design/vmma_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmma_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module vmma_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/vmma_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmma_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vmma_divider import vmma_pkg::*; #(
   parameter int NUM_W = 21,
   parameter int DEN_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output div_status_type   status,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      fits    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_W);
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // shift the quotient bit in where the dividend bit left
         num_in  = {num_ff[NUM_W-2:0], fits};
         rem_in  = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = num_ff;

endmodule

// ===== design/valid_masked_moving_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valid_masked_moving_average
// Moving average over a ring of DEPTH readings, each good or failed, with
// a rounded mean of the good readings in the window.
// ----------------------------------------------------------------------------
// channel   dir  handshake     beat
// req_bus   in   valid/ready   operation, sample_value
// rsp_bus   out  valid/ready   last_ok, last_value, average_ok, average_value
//
// One request at a time: from accept, the block steps through update, divider start,
// divide (one quotient bit per cycle) and output before the response is posted.
// Ring values sit in a RAM; per-entry live bits in flops, cleared at reset
// and by a clear request, so no clearing pass is needed.
// A response waiting on rsp_bus does not block the next request; its fields
// sit in their own registers and hold until the beat is taken.
// ----------------------------------------------------------------------------
module valid_masked_moving_average import vmma_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   vmma_req_if.sink   req_bus,
   vmma_rsp_if.source rsp_bus
);

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = DATA_W + $clog2(DEPTH);
   localparam int NUM_W  = SUM_W + 1;
   localparam int DEN_W  = CNT_W + 1;
   localparam int ENT_W  = DATA_W + 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UPDATE = 3'd1;
   localparam logic [2:0] S_START  = 3'd2;
   localparam logic [2:0] S_DIVIDE = 3'd3;
   localparam logic [2:0] S_OUTPUT = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [OP_W-1:0]          op_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [DEPTH-1:0]         live_ff, live_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     last_ok_ff, last_ok_in;
   logic signed [DATA_W-1:0] last_val_ff, last_val_in;
   logic                     neg_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_last_ok_ff;
   logic signed [DATA_W-1:0] rsp_last_val_ff;
   logic                     avg_ok_ff;
   logic signed [DATA_W-1:0] avg_val_ff;

   logic                     accept;
   logic                     rsp_free;
   logic [SLOT_W-1:0]        next_slot;
   logic                     ram_wr;
   logic [ENT_W-1:0]         ram_wdata;
   logic [SLOT_W-1:0]        ram_raddr;
   logic [ENT_W-1:0]         ram_rdata;
   logic signed [DATA_W-1:0] old_val;
   logic                     old_valid;
   logic                     op_good;
   logic signed [SUM_W-1:0]  sub_term, add_term;
   logic [SUM_W-1:0]         mag;
   logic [NUM_W-1:0]         numer;
   logic                     div_start;
   div_status_type           div_status;
   logic [NUM_W-1:0]         quot;
   logic signed [DATA_W-1:0] q16;

   assign accept   = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign next_slot = (slot_ff == SLOT_W'(DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
   assign ram_raddr = (req_bus.operation == OP_NONE) ? slot_ff : next_slot;

   assign op_good   = (op_ff == OP_GOOD);
   assign old_val   = ram_rdata[DATA_W-1:0];
   assign old_valid = live_ff[next_slot] & ram_rdata[DATA_W];
   assign sub_term  = old_valid ? SUM_W'(old_val) : '0;
   assign add_term  = op_good ? SUM_W'(value_ff) : '0;

   assign ram_wr    = (state_ff == S_UPDATE) && ((op_ff == OP_GOOD) || (op_ff == OP_FAIL));
   assign ram_wdata = {op_good, op_good ? value_ff : DATA_W'(0)};

   assign mag       = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign numer     = {mag, 1'b0} + NUM_W'(count_ff);
   assign div_start = (state_ff == S_START);
   assign q16       = quot[DATA_W-1:0];

   vmma_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (next_slot),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   vmma_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numer),
      .divisor  ({count_ff, 1'b0}),
      .status   (div_status),
      .quotient (quot)
   );

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      live_in      = live_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      last_ok_in   = last_ok_ff;
      last_val_in  = last_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            state_in = S_START;
            case (op_ff)
               OP_GOOD, OP_FAIL: begin
                  slot_in            = next_slot;
                  live_in[next_slot] = 1'b1;
                  sum_in             = sum_ff - sub_term + add_term;
                  count_in           = count_ff - CNT_W'(old_valid) + CNT_W'(op_good);
                  last_ok_in         = op_good;
                  last_val_in        = op_good ? value_ff : '0;
               end
               OP_CLEAR: begin
                  live_in     = '0;
                  sum_in      = '0;
                  count_in    = '0;
                  last_ok_in  = 1'b0;
                  last_val_in = '0;
               end
               default: begin
                  last_ok_in  = live_ff[slot_ff] & ram_rdata[DATA_W];
                  last_val_in = last_ok_in ? old_val : '0;
               end
            endcase
         end
         S_START: begin
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_status.done) begin
               state_in = S_OUTPUT;
            end
         end
         S_OUTPUT: begin
            // hold until the response register frees up
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= '0;
         live_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         live_ff      <= live_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ok_ff  <= last_ok_in;
      last_val_ff <= last_val_in;
      if (accept) begin
         op_ff    <= req_bus.operation;
         value_ff <= req_bus.sample_value;
      end
      if (state_ff == S_START) begin
         neg_ff <= sum_ff[SUM_W-1];
      end
      if ((state_ff == S_OUTPUT) && rsp_free) begin
         rsp_last_ok_ff  <= last_ok_ff;
         rsp_last_val_ff <= last_val_ff;
         avg_ok_ff       <= (count_ff != '0);
         avg_val_ff      <= (count_ff == '0) ? '0 : (neg_ff ? -q16 : q16);
      end
   end

   assign req_bus.ready         = (state_ff == S_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.last_ok       = rsp_last_ok_ff;
   assign rsp_bus.last_value    = rsp_last_val_ff;
   assign rsp_bus.average_ok    = avg_ok_ff;
   assign rsp_bus.average_value = avg_val_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("valid count exceeds window depth");

   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (sum_ff == '0))
      else $error("empty window with nonzero sum");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) && (op_ff == OP_CLEAR) |=> (live_ff == '0) && (count_ff == '0))
      else $error("clear left live entries");

   a_avg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.average_ok |-> (rsp_bus.average_value == '0))
      else $error("average value nonzero with empty window");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == S_DIVIDE))
      else $error("divider finished outside divide phase");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for valid_masked_moving_average. A directed table
// covers the boundary values, every operation code, a clear and a full ring
// that wraps. Random segments follow: mixed traffic, runs of full-scale
// readings, small readings that hit the rounding halves, and long runs of
// failed readings. Both handshakes stall at random. Every response beat is
// compared field by field against its pinned table row or a window model kept in the bench.
// ----------------------------------------------------------------------------
module testbench import vmma_pkg::*; ();

   localparam int RING          = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 700;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTED  = 10;
   localparam int STALL_PERCENT = 6;

   typedef struct packed {
      logic                     last_ok;
      logic signed [DATA_W-1:0] last_value;
      logic                     average_ok;
      logic signed [DATA_W-1:0] average_value;
   } window_report_type;

   typedef struct {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
      bit                       pinned;
      window_report_type        report;
   } directed_row_type;

   typedef enum int {MIX_FEED, FULL_SCALE_FEED, SMALL_FEED, FAULTY_FEED} feed_mode_type;

   logic clock;
   logic reset;

   vmma_req_if req_bus ();
   vmma_rsp_if rsp_bus ();

   valid_masked_moving_average #(.DEPTH(RING)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // window model
   logic signed [DATA_W-1:0] ring_value [RING];
   bit                       ring_live  [RING];
   int                       ring_slot;
   int                       window_total;
   int                       live_count;

   window_report_type pending_reports [$];
   directed_row_type  directed_rows [$];

   int  cycle_count;
   int  mismatches;
   int  responses_checked;
   int  op_tally [4];
   int  ring_wraps;
   bit  steady;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_reports.size());
         $display("valid_masked_moving_average: mismatch");
         $finish;
      end
   end

   task automatic step_window(input logic [OP_W-1:0] op,
                              input logic signed [DATA_W-1:0] val,
                              output window_report_type r);
      int mag;
      int q;
      case (op)
         OP_GOOD, OP_FAIL: begin
            ring_slot = ring_slot + 1;
            if (ring_slot >= RING) begin
               ring_slot = 0;
               ring_wraps++;
            end
            // the overwritten reading leaves the window
            if (ring_live[ring_slot]) begin
               window_total -= ring_value[ring_slot];
               live_count--;
            end
            ring_live[ring_slot]  = (op == OP_GOOD);
            ring_value[ring_slot] = (op == OP_GOOD) ? val : '0;
            if (op == OP_GOOD) begin
               window_total += val;
               live_count++;
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < RING; i++) begin
               ring_live[i]  = 1'b0;
               ring_value[i] = '0;
            end
            window_total = 0;
            live_count   = 0;
         end
         default: ;
      endcase
      r.last_ok    = ring_live[ring_slot];
      r.last_value = ring_live[ring_slot] ? ring_value[ring_slot] : '0;
      r.average_ok = (live_count > 0);
      if (live_count == 0) begin
         r.average_value = '0;
      end else begin
         // round the magnitude half up, then restore the sign
         mag = (window_total < 0) ? -window_total : window_total;
         q   = (2 * mag + live_count) / (2 * live_count);
         r.average_value = (window_total < 0) ? DATA_W'(-q) : DATA_W'(q);
      end
   endtask

   task automatic push_beat(input logic [OP_W-1:0] op,
                            input logic signed [DATA_W-1:0] val,
                            input bit pinned,
                            input window_report_type pinned_report);
      window_report_type predicted;
      @(negedge clock);
      while (!steady && $urandom_range(99) < STALL_PERCENT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.operation    = op;
      req_bus.sample_value = val;
      do @(posedge clock); while (!req_bus.ready);
      step_window(op, val, predicted);
      pending_reports.push_back(pinned ? pinned_report : predicted);
      op_tally[op]++;
   endtask

   task automatic add_row(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val,
                          input bit pinned, input window_report_type r);
      directed_row_type row;
      row.op     = op;
      row.value  = val;
      row.pinned = pinned;
      row.report = r;
      directed_rows.push_back(row);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value(input feed_mode_type mode);
      case (mode)
         FULL_SCALE_FEED: return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
         SMALL_FEED:      return DATA_W'($urandom_range(8) - 4);
         default: begin
            case ($urandom_range(9))
               0:       return 16'sh7fff;
               1:       return 16'sh8000;
               2:       return DATA_W'($urandom_range(6) - 3);
               default: return DATA_W'($urandom);
            endcase
         end
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input feed_mode_type mode);
      int r;
      r = $urandom_range(99);
      case (mode)
         FULL_SCALE_FEED: return (r < 90) ? OP_GOOD : OP_FAIL;
         SMALL_FEED:      return (r < 80) ? OP_GOOD : (r < 95) ? OP_FAIL : OP_NONE;
         FAULTY_FEED:     return (r < 30) ? OP_GOOD : (r < 90) ? OP_FAIL :
                                 (r < 95) ? OP_CLEAR : OP_NONE;
         default:         return (r < 60) ? OP_GOOD : (r < 85) ? OP_FAIL :
                                 (r < 93) ? OP_CLEAR : OP_NONE;
      endcase
   endfunction

   // response side: random stalls, compare against the oldest expectation
   always @(negedge clock) begin
      if (!reset) begin
         rsp_bus.ready <= steady || ($urandom_range(99) >= STALL_PERCENT);
      end
   end

   always @(posedge clock) begin
      window_report_type want;
      window_report_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.last_ok       = rsp_bus.last_ok;
         got.last_value    = rsp_bus.last_value;
         got.average_ok    = rsp_bus.average_ok;
         got.average_value = rsp_bus.average_value;
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
               $display("unexpected response beat: last %0b/%0d average %0b/%0d",
                        got.last_ok, got.last_value, got.average_ok, got.average_value);
            end
         end else begin
            want = pending_reports.pop_front();
            responses_checked++;
            if (got.last_ok !== want.last_ok || got.last_value !== want.last_value ||
                got.average_ok !== want.average_ok ||
                got.average_value !== want.average_value) begin
               mismatches++;
               if (mismatches <= MAX_REPORTED) begin
                  $display("response %0d: want %0b/%0d %0b/%0d, got %0b/%0d %0b/%0d",
                           responses_checked, want.last_ok, want.last_value,
                           want.average_ok, want.average_value, got.last_ok,
                           got.last_value, got.average_ok, got.average_value);
               end
            end
         end
      end
   end

   initial begin
      window_report_type zeros;
      feed_mode_type     mode;
      logic [OP_W-1:0]   op;
      int                counted;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.operation    = OP_NONE;
      req_bus.sample_value = '0;
      rsp_bus.ready        = 1'b0;
      steady               = 1'b0;
      cycle_count          = 0;
      mismatches           = 0;
      responses_checked    = 0;
      ring_wraps           = 0;
      op_tally             = '{default: 0};
      ring_slot            = 0;
      window_total         = 0;
      live_count           = 0;
      for (int i = 0; i < RING; i++) begin
         ring_value[i] = '0;
         ring_live[i]  = 1'b0;
      end
      zeros = '0;

      add_row(OP_NONE,  16'sh5a5a, 1, zeros);
      add_row(OP_GOOD,  16'sh7fff, 1, '{1'b1, 16'sh7fff, 1'b1, 16'sh7fff});
      add_row(OP_GOOD,  16'sh8000, 1, '{1'b1, 16'sh8000, 1'b1, -16'sd1});
      add_row(OP_FAIL,  16'sh7fff, 0, zeros);
      add_row(OP_NONE,  16'shffff, 0, zeros);
      add_row(OP_CLEAR, 16'sh1234, 1, zeros);
      add_row(OP_NONE,  16'sh0000, 1, zeros);
      add_row(OP_GOOD,  16'sh8000, 1, '{1'b1, 16'sh8000, 1'b1, 16'sh8000});
      add_row(OP_CLEAR, 16'shffff, 1, zeros);
      // fill the whole ring at negative full scale, then wrap over a live entry
      for (int i = 0; i <= RING; i++) begin
         add_row(OP_GOOD, 16'sh8000, 1, '{1'b1, 16'sh8000, 1'b1, 16'sh8000});
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         push_beat(directed_rows[i].op, directed_rows[i].value,
                   directed_rows[i].pinned, directed_rows[i].report);
      end

      counted = 0;
      mode    = MIX_FEED;
      while (counted < RANDOM_ITEMS) begin
         if (counted % 20 == 0) begin
            mode = feed_mode_type'($urandom_range(3));
         end
         steady = (counted >= 250 && counted < 380);
         if (counted == 150) begin
            // hold off until the block has answered everything
            @(negedge clock);
            req_bus.valid = 1'b0;
            while (pending_reports.size() != 0) @(posedge clock);
         end
         op = pick_op(mode);
         push_beat(op, pick_value(mode), 0, zeros);
         if (op != OP_NONE) begin
            counted++;
         end
      end
      steady = 1'b0;

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("sent %0d good, %0d failed, %0d clear, %0d unused; %0d ring wraps",
               op_tally[OP_GOOD], op_tally[OP_FAIL], op_tally[OP_CLEAR],
               op_tally[OP_NONE], ring_wraps);
      $display("responses checked: %0d, mismatches: %0d", responses_checked, mismatches);
      if (mismatches == 0 && pending_reports.size() == 0) begin
         $display("valid_masked_moving_average: match");
      end else begin
         $display("valid_masked_moving_average: mismatch");
      end
      $finish;
   end

endmodule
